[rtl/three_rotor_substitution_cipher_top_macros.svh]
`ifndef THREE_ROTOR_SUBSTITUTION_CIPHER_TOP_MACROS_SVH
`define THREE_ROTOR_SUBSTITUTION_CIPHER_TOP_MACROS_SVH

// Concurrent check sampled on clk, off while rst_n is low.
`define TRSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Signal must hold its value in the cycle after cond.
`define TRSC_ASSERT_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

[rtl/trsc_pkg.sv]
`timescale 1ns / 1ps

package trsc_pkg;

    localparam int LETTER_W    = 5;
    localparam int SEL_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int LETTER_SPAN = 1 << LETTER_W;

    localparam logic [LETTER_W-1:0] NOTCH_RESET = 5'd25;
    localparam logic [LETTER_W-1:0] START_RESET = 5'd0;
    localparam logic [LETTER_W-1:0] NOTCH_NONE  = 5'd31;

    localparam logic [SEL_W-1:0] ROTOR_ONE   = 2'd0;
    localparam logic [SEL_W-1:0] ROTOR_TWO   = 2'd1;
    localparam logic [SEL_W-1:0] ROTOR_THREE = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_START   = 2'd1,
        OP_ENCRYPT = 2'd2,
        OP_DECRYPT = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOTCH_ONE   = 3'd0,
        CFG_NOTCH_TWO   = 3'd1,
        CFG_NOTCH_THREE = 3'd2,
        CFG_START_ONE   = 3'd3,
        CFG_START_TWO   = 3'd4,
        CFG_START_THREE = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                load;
        logic                start;
        logic                step;
        logic [LETTER_W-1:0] load_index;
        logic [LETTER_W-1:0] load_letter;
    } rotor_ctrl_t;

endpackage

[rtl/three_rotor_substitution_cipher_top.sv]
`timescale 1ns / 1ps
// A word is registered in the input stage on acceptance; its result word is then registered in the output register.
// Throughput: one word per cycle while the result output is not stalled; load and start words produce no result.
// Stepping and the three-rotor lookup are combinational from the input register; result and offsets register together.
// Reset (rst_n low, async): rotor offsets zero, notches one and two 25, start letters 0, pipeline empty.
// Wiring tables are not reset and must be loaded before use.

module three_rotor_substitution_cipher_top #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [trsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trsc_pkg::LETTER_W-1:0]     cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  trsc_pkg::op_t                     operation,
    input  logic [trsc_pkg::SEL_W-1:0]        rotor_select,
    input  logic [trsc_pkg::LETTER_W-1:0]     table_index,
    input  logic [trsc_pkg::LETTER_W-1:0]     letter,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [trsc_pkg::LETTER_W-1:0]     result_letter
);
    import trsc_pkg::*;

    localparam int IW = $clog2(ALPHABET_SIZE);
    localparam logic [LETTER_W:0] SIZE_EXT = (LETTER_W + 1)'(ALPHABET_SIZE);

    typedef logic [IW-1:0] sym_t;

    function automatic logic [LETTER_SPAN-1:0][IW-1:0] build_mod_lut();
        logic [LETTER_SPAN-1:0][IW-1:0] lut;
        begin
            for (int i = 0; i < LETTER_SPAN; i++)
            begin
                lut[i] = IW'(i % ALPHABET_SIZE);
            end
            return lut;
        end
    endfunction

    localparam logic [LETTER_SPAN-1:0][IW-1:0] MOD_LUT = build_mod_lut();

    logic [LETTER_W-1:0] notch_one_reg;
    logic [LETTER_W-1:0] notch_two_reg;
    logic [LETTER_W-1:0] start_one_reg;
    logic [LETTER_W-1:0] start_two_reg;
    logic [LETTER_W-1:0] start_three_reg;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    op_t                 s1_op_reg;
    logic [SEL_W-1:0]    s1_sel_reg;
    logic [LETTER_W-1:0] s1_index_reg;
    logic [LETTER_W-1:0] s1_letter_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [LETTER_W-1:0] result_reg;
    logic [LETTER_W-1:0] result_next;

    logic        in_take;
    logic        s1_has_result;
    logic        s1_go;
    logic        crypt_go;
    logic        start_go;
    logic        load_go;
    logic        hit_one;
    logic        hit_two;
    sym_t        text_sym;
    sym_t        enc_one;
    sym_t        enc_two;
    sym_t        enc_three;
    sym_t        dec_one;
    sym_t        dec_two;
    sym_t        dec_three;
    rotor_ctrl_t ctrl_one;
    rotor_ctrl_t ctrl_two;
    rotor_ctrl_t ctrl_three;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notch_one_reg   <= NOTCH_RESET;
            notch_two_reg   <= NOTCH_RESET;
            start_one_reg   <= START_RESET;
            start_two_reg   <= START_RESET;
            start_three_reg <= START_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_NOTCH_ONE:   notch_one_reg   <= cfg_data;
                CFG_NOTCH_TWO:   notch_two_reg   <= cfg_data;
                CFG_START_ONE:   start_one_reg   <= cfg_data;
                CFG_START_TWO:   start_two_reg   <= cfg_data;
                CFG_START_THREE: start_three_reg <= cfg_data;
                default:         ; // notch three has no effect
            endcase
        end
    end

    // handshake
    assign s1_has_result = s1_op_reg inside {OP_ENCRYPT, OP_DECRYPT};
    assign s1_go    = s1_valid_reg && (!s1_has_result || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (crypt_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg     <= operation;
            s1_sel_reg    <= rotor_select;
            s1_index_reg  <= table_index;
            s1_letter_reg <= letter;
        end
        if (crypt_go)
        begin
            result_reg <= result_next;
        end
    end

    // rotor control
    assign crypt_go = s1_go && s1_has_result;
    assign start_go = s1_go && (s1_op_reg == OP_START);
    assign load_go  = s1_go && (s1_op_reg == OP_LOAD)
                      && ({1'b0, s1_index_reg} < SIZE_EXT)
                      && ({1'b0, s1_letter_reg} < SIZE_EXT);

    always_comb
    begin
        ctrl_one.load        = load_go && (s1_sel_reg == ROTOR_ONE);
        ctrl_one.start       = start_go;
        ctrl_one.step        = crypt_go;
        ctrl_one.load_index  = s1_index_reg;
        ctrl_one.load_letter = s1_letter_reg;

        ctrl_two.load        = load_go && (s1_sel_reg == ROTOR_TWO);
        ctrl_two.start       = start_go;
        ctrl_two.step        = crypt_go && hit_one;
        ctrl_two.load_index  = s1_index_reg;
        ctrl_two.load_letter = s1_letter_reg;

        ctrl_three.load        = load_go && (s1_sel_reg == ROTOR_THREE);
        ctrl_three.start       = start_go;
        ctrl_three.step        = crypt_go && hit_one && hit_two;
        ctrl_three.load_index  = s1_index_reg;
        ctrl_three.load_letter = s1_letter_reg;
    end

    assign text_sym = MOD_LUT[s1_letter_reg];

    trsc_rotor #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_rotor_one (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl_one),
        .notch        (notch_one_reg),
        .start_letter (start_one_reg),
        .fwd_in       (text_sym),
        .inv_in       (dec_two),
        .fwd_out      (enc_one),
        .inv_out      (dec_one),
        .notch_hit    (hit_one)
    );

    trsc_rotor #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_rotor_two (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl_two),
        .notch        (notch_two_reg),
        .start_letter (start_two_reg),
        .fwd_in       (enc_one),
        .inv_in       (dec_three),
        .fwd_out      (enc_two),
        .inv_out      (dec_two),
        .notch_hit    (hit_two)
    );

    trsc_rotor #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_rotor_three (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl_three),
        .notch        (NOTCH_NONE),
        .start_letter (start_three_reg),
        .fwd_in       (enc_two),
        .inv_in       (text_sym),
        .fwd_out      (enc_three),
        .inv_out      (dec_three),
        .notch_hit    ()
    );

    assign result_next = (s1_op_reg == OP_ENCRYPT) ? LETTER_W'(enc_three) : LETTER_W'(dec_one);

    assign out_valid     = out_valid_reg;
    assign result_letter = result_reg;

endmodule

[rtl/trsc_rotor.sv]
`timescale 1ns / 1ps

module trsc_rotor #(
    parameter int ALPHABET_SIZE = 26,
    localparam int IW = $clog2(ALPHABET_SIZE)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  trsc_pkg::rotor_ctrl_t            ctrl,
    input  logic [trsc_pkg::LETTER_W-1:0]    notch,
    input  logic [trsc_pkg::LETTER_W-1:0]    start_letter,
    input  logic [IW-1:0]                    fwd_in,
    input  logic [IW-1:0]                    inv_in,
    output logic [IW-1:0]                    fwd_out,
    output logic [IW-1:0]                    inv_out,
    output logic                             notch_hit
);
    import trsc_pkg::*;

    localparam logic [IW:0] SIZE = (IW + 1)'(ALPHABET_SIZE);

    logic [IW-1:0]            fwd_reg [ALPHABET_SIZE];
    logic [IW-1:0]            inv_reg [ALPHABET_SIZE];
    logic [IW-1:0]            offset_reg;
    logic [IW-1:0]            offset_next;
    logic [IW-1:0]            offset_inc;
    logic [IW-1:0]            offset_use;
    logic [IW-1:0]            start_pos;
    logic [IW-1:0]            load_index;
    logic [IW-1:0]            load_letter;
    logic [ALPHABET_SIZE-1:0] notch_vec;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            if (sum >= SIZE)
            begin
                sum = sum - SIZE;
            end
            return sum[IW-1:0];
        end
    endfunction

    function automatic logic [IW-1:0] wrap_sub(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW:0] diff;
        begin
            if (a >= b)
            begin
                diff = {1'b0, a} - {1'b0, b};
            end
            else
            begin
                diff = {1'b0, a} + SIZE - {1'b0, b};
            end
            return diff[IW-1:0];
        end
    endfunction

    assign load_index  = ctrl.load_index[IW-1:0];
    assign load_letter = ctrl.load_letter[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            fwd_reg[load_index]  <= load_letter;
            inv_reg[load_letter] <= load_index;
        end
    end

    // lowest position showing the start letter, zero if none
    always_comb
    begin
        start_pos = '0;
        for (int p = ALPHABET_SIZE - 1; p >= 0; p--)
        begin
            if (LETTER_W'(fwd_reg[p]) == start_letter)
            begin
                start_pos = IW'(p);
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < ALPHABET_SIZE; p++)
        begin
            notch_vec[p] = (LETTER_W'(fwd_reg[p]) == notch);
        end
    end

    assign offset_inc = wrap_add(offset_reg, IW'(1));
    assign offset_use = ctrl.step ? offset_inc : offset_reg;
    assign notch_hit  = notch_vec[offset_inc];

    always_comb
    begin
        if (ctrl.start)
        begin
            offset_next = start_pos;
        end
        else
        begin
            offset_next = offset_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

    assign fwd_out = fwd_reg[wrap_add(fwd_in, offset_use)];
    assign inv_out = wrap_sub(inv_reg[inv_in], offset_use);

endmodule

[rtl/trsc_checker.sv]
`timescale 1ns / 1ps
`include "three_rotor_substitution_cipher_top_macros.svh"

module trsc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_write,
    input logic [trsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [trsc_pkg::LETTER_W-1:0]     cfg_data,
    input logic                              in_valid,
    input logic                              in_ready,
    input trsc_pkg::op_t                     operation,
    input logic [trsc_pkg::SEL_W-1:0]        rotor_select,
    input logic [trsc_pkg::LETTER_W-1:0]     table_index,
    input logic [trsc_pkg::LETTER_W-1:0]     letter,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [trsc_pkg::LETTER_W-1:0]     result_letter
);
    import trsc_pkg::*;

    `TRSC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")
    `TRSC_ASSERT_HOLD(a_out_stable, out_valid && !out_ready, result_letter, "result changed while stalled")
    // input side only stalls behind a blocked result
    `TRSC_ASSERT(a_stall_cause, !in_ready |-> out_valid && !out_ready, "input stalled without output backpressure")
    // a new result comes only from a cipher word, taken into the input stage and then into the result register
    `TRSC_ASSERT(a_result_source, $rose(out_valid) |-> $past(in_valid && in_ready, 2) && ($past(operation, 2) == OP_ENCRYPT || $past(operation, 2) == OP_DECRYPT), "result without a cipher word")

endmodule

bind three_rotor_substitution_cipher_top trsc_checker u_trsc_checker (.*);
